// ===== src/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg
// Shared constants and types for the swept box collision pipeline.
// ----------------------------------------------------------------------------
package sac_pkg;

	// default widths of coordinates (Q16.8) and times (Q4.16)
	localparam int COORD_WIDTH_DEF = 24;
	localparam int TIME_WIDTH_DEF  = 20;

	// frame time register and result time field
	localparam int              FT_W     = 20;
	localparam logic [FT_W-1:0] FT_RESET = 20'd1092;

	// fraction bits of a time quotient
	localparam int FRAC_BITS = 16;

	// per-axis decision, travels alongside the divider pipeline
	typedef struct packed {
		logic reject;    // apart and not closing in
		logic use_entry; // entry quotient narrows the start of the window
		logic use_exit;  // exit quotient narrows the end of the window
	} axis_ctrl_t;

endpackage

// ===== src/sac_axis.sv =====
// ----------------------------------------------------------------------------
// sac_axis
// One axis: relative velocity, edge distances and the case decision by sign.
// ----------------------------------------------------------------------------
module sac_axis import sac_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [CW-1:0] a_min,
	input  logic signed [CW-1:0] a_max,
	input  logic signed [CW-1:0] a_vel,
	input  logic signed [CW-1:0] b_min,
	input  logic signed [CW-1:0] b_max,
	input  logic signed [CW-1:0] b_vel,
	output axis_ctrl_t          ctrl_s1,
	output logic signed [CW:0]  ent_num_s1,
	output logic signed [CW:0]  ext_num_s1
);

	logic signed [CW:0] vel;
	logic signed [CW:0] d_hi;  // a_max - b_min
	logic signed [CW:0] d_lo;  // a_min - b_max
	logic               amin_gt_bmax;
	logic               amax_lt_bmin;
	logic               bmin_lt_amax;
	logic               amin_lt_bmax;
	logic               neg;
	logic               pos;
	axis_ctrl_t         ctrl;

	// exact differences, one bit wider than the coordinates
	always_comb begin
		vel  = {b_vel[CW-1], b_vel} - {a_vel[CW-1], a_vel};
		d_hi = {a_max[CW-1], a_max} - {b_min[CW-1], b_min};
		d_lo = {a_min[CW-1], a_min} - {b_max[CW-1], b_max};
		amin_gt_bmax = a_min > b_max;
		amax_lt_bmin = a_max < b_min;
		bmin_lt_amax = b_min < a_max;
		amin_lt_bmax = a_min < b_max;
		neg = vel[CW];
		pos = !vel[CW] && (vel != '0);
	end

	// case split on the sign of the relative velocity
	always_comb begin
		if (neg) begin
			ctrl.reject    = amin_gt_bmax;
			ctrl.use_entry = amax_lt_bmin;
			ctrl.use_exit  = amin_lt_bmax;
		end else if (pos) begin
			ctrl.reject    = amax_lt_bmin;
			ctrl.use_entry = amin_gt_bmax;
			ctrl.use_exit  = bmin_lt_amax;
		end else begin
			ctrl.reject    = amax_lt_bmin || amin_gt_bmax;
			ctrl.use_entry = 1'b0;
			ctrl.use_exit  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1    <= ctrl;
			ent_num_s1 <= neg ? d_hi : d_lo;
			ext_num_s1 <= neg ? d_lo : d_hi;
		end
	end

endmodule

// ===== src/sac_tdiv.sv =====
// ----------------------------------------------------------------------------
// sac_tdiv
// Pipelined saturating divider: (|num| << 16) / |den|, one quotient bit per
// stage.
// ----------------------------------------------------------------------------
module sac_tdiv import sac_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF,
	parameter int TW = TIME_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [CW:0]  num,
	input  logic signed [CW:0]  den,
	output logic [TW-1:0]       quo
);

	localparam int NW = CW + 1 + FRAC_BITS + TW;  // widened dividend
	localparam int RW = CW + 2;                   // partial remainder

	logic [CW:0]   nabs;
	logic [CW:0]   dabs;
	logic [CW:0]   nmag_s1;
	logic [CW:0]   dmag_s1;
	logic [NW-1:0] n_ext;
	logic [NW-1:0] d_ext;

	logic [RW-1:0] rem_sk [TW+1];
	logic [TW-1:0] quo_sk [TW+1];
	logic [TW-1:0] nlo_sk [TW+1];
	logic [CW:0]   dmag_sk[TW+1];
	logic          ovf_sk [TW+1];

	// stage 1: magnitudes
	always_comb begin
		nabs = num[CW] ? $unsigned(-num) : $unsigned(num);
		dabs = den[CW] ? $unsigned(-den) : $unsigned(den);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s1 <= nabs;
			dmag_s1 <= dabs;
		end
	end

	// stage 2: overflow check and initial remainder
	always_comb begin
		n_ext = NW'(nmag_s1) << FRAC_BITS;
		d_ext = NW'(dmag_s1) << TW;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_sk[0]  <= n_ext >= d_ext;
			rem_sk[0]  <= n_ext[TW+RW-1:TW];
			nlo_sk[0]  <= n_ext[TW-1:0];
			dmag_sk[0] <= dmag_s1;
			quo_sk[0]  <= '0;
		end
	end

	// restoring steps, most significant quotient bit first
	for (genvar k = 0; k < TW; k++) begin : g_step
		logic [RW-1:0] trial;
		logic          ge;

		always_comb begin
			trial = {rem_sk[k][RW-2:0], nlo_sk[k][TW-1-k]};
			ge    = trial >= RW'(dmag_sk[k]);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k+1]  <= ge ? (trial - RW'(dmag_sk[k])) : trial;
				quo_sk[k+1]  <= quo_sk[k] | (TW'(ge) << (TW-1-k));
				nlo_sk[k+1]  <= nlo_sk[k];
				dmag_sk[k+1] <= dmag_sk[k];
				ovf_sk[k+1]  <= ovf_sk[k];
			end
		end
	end

	// saturate at the top of the time range
	assign quo = ovf_sk[TW] ? '1 : quo_sk[TW];

endmodule

// ===== src/sac_window.sv =====
// ----------------------------------------------------------------------------
// sac_window
// Merges both axes into one time window and decides hit. Two stages.
// ----------------------------------------------------------------------------
module sac_window import sac_pkg::*; #(
	parameter int TW = TIME_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            en,
	input  axis_ctrl_t      ctrl_x,
	input  axis_ctrl_t      ctrl_y,
	input  logic [TW-1:0]   qx_ent,
	input  logic [TW-1:0]   qx_ext,
	input  logic [TW-1:0]   qy_ent,
	input  logic [TW-1:0]   qy_ext,
	input  logic [FT_W-1:0] frame_time,
	output logic            hit_s2,
	output logic [FT_W-1:0] fct_s2
);

	localparam int WW = (TW > FT_W) ? TW : FT_W;
	localparam logic [TW-1:0] TMAX = '1;

	logic [TW-1:0] ft_clamp;
	logic [TW-1:0] ex;
	logic [TW-1:0] ey;
	logic [TW-1:0] xx;
	logic [TW-1:0] xy;
	logic [TW-1:0] t0;
	logic [TW-1:0] t1a;
	logic [TW-1:0] t1b;
	logic [TW-1:0] t0_s1;
	logic [TW-1:0] t1_s1;
	logic          rej_s1;
	logic          hit;

	// window start is the latest entry, end the earliest exit capped at the frame time
	always_comb begin
		ft_clamp = (WW'(frame_time) > WW'(TMAX)) ? TMAX : TW'(frame_time);
		ex  = ctrl_x.use_entry ? qx_ent : '0;
		ey  = ctrl_y.use_entry ? qy_ent : '0;
		xx  = ctrl_x.use_exit ? qx_ext : TMAX;
		xy  = ctrl_y.use_exit ? qy_ext : TMAX;
		t0  = (ex > ey) ? ex : ey;
		t1a = (xx < xy) ? xx : xy;
		t1b = (t1a < ft_clamp) ? t1a : ft_clamp;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s1  <= t0;
			t1_s1  <= t1b;
			rej_s1 <= ctrl_x.reject || ctrl_y.reject;
		end
	end

	// empty window or rejection gives no hit
	assign hit = !rej_s1 && (t0_s1 <= t1_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s2 <= hit;
			fct_s2 <= hit ? FT_W'(t0_s1) : '0;
		end
	end

endmodule

// ===== src/swept_aabb_collision.sv =====
// ----------------------------------------------------------------------------
// swept_aabb_collision
// Swept 2D axis-aligned box collision test, fixed point, fully pipelined.
//
// channel   | handshake                | payload
// ----------+--------------------------+-----------------------------------
// input     | in_valid / in_ready      | a_*, b_* corners and velocities
// result    | out_valid / out_ready    | hit, first_contact_time
// config    | cfg_we (no wait)         | cfg_wdata -> frame_time
//
// One item per cycle while the pipeline is not held; stages: one setup stage,
// two divider setup stages, one stage per quotient bit, two window stages.
// The whole pipeline advances together; it holds while a result waits and
// out_ready is low, so in_ready follows that single enable.
// Reset clears the valid bits and loads frame_time with its reset value.
// ----------------------------------------------------------------------------
module swept_aabb_collision import sac_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [FT_W-1:0]              cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_WIDTH-1:0] a_min_x,
	input  logic signed [COORD_WIDTH-1:0] a_min_y,
	input  logic signed [COORD_WIDTH-1:0] a_max_x,
	input  logic signed [COORD_WIDTH-1:0] a_max_y,
	input  logic signed [COORD_WIDTH-1:0] a_vel_x,
	input  logic signed [COORD_WIDTH-1:0] a_vel_y,
	input  logic signed [COORD_WIDTH-1:0] b_min_x,
	input  logic signed [COORD_WIDTH-1:0] b_min_y,
	input  logic signed [COORD_WIDTH-1:0] b_max_x,
	input  logic signed [COORD_WIDTH-1:0] b_max_y,
	input  logic signed [COORD_WIDTH-1:0] b_vel_x,
	input  logic signed [COORD_WIDTH-1:0] b_vel_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [FT_W-1:0]              first_contact_time
);

	localparam int DL = 2 + TIME_WIDTH;  // divider latency
	localparam int L  = 1 + DL + 2;      // total latency

	logic                       en;
	logic [FT_W-1:0]            frame_time_q;
	logic [L-1:0]               vld_q;
	axis_ctrl_t                 cx_s1;
	axis_ctrl_t                 cy_s1;
	axis_ctrl_t                 cx_q [DL];
	axis_ctrl_t                 cy_q [DL];
	logic signed [COORD_WIDTH:0] xent_s1;
	logic signed [COORD_WIDTH:0] xext_s1;
	logic signed [COORD_WIDTH:0] yent_s1;
	logic signed [COORD_WIDTH:0] yext_s1;
	logic [TIME_WIDTH-1:0]      qx_ent;
	logic [TIME_WIDTH-1:0]      qx_ext;
	logic [TIME_WIDTH-1:0]      qy_ent;
	logic [TIME_WIDTH-1:0]      qy_ext;

	// global advance: hold only while a result waits and out_ready is low
	assign en        = !vld_q[L-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[L-1];

	// frame time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_time_q <= FT_RESET;
		end else if (cfg_we) begin
			frame_time_q <= cfg_wdata;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], in_valid};
		end
	end

	// per-axis setup
	sac_axis #(.CW(COORD_WIDTH)) u_axis_x (
		.clk(clk), .en(en),
		.a_min(a_min_x), .a_max(a_max_x), .a_vel(a_vel_x),
		.b_min(b_min_x), .b_max(b_max_x), .b_vel(b_vel_x),
		.ctrl_s1(cx_s1), .ent_num_s1(xent_s1), .ext_num_s1(xext_s1)
	);

	sac_axis #(.CW(COORD_WIDTH)) u_axis_y (
		.clk(clk), .en(en),
		.a_min(a_min_y), .a_max(a_max_y), .a_vel(a_vel_y),
		.b_min(b_min_y), .b_max(b_max_y), .b_vel(b_vel_y),
		.ctrl_s1(cy_s1), .ent_num_s1(yent_s1), .ext_num_s1(yext_s1)
	);

	// the four quotients, relative velocity of that axis as divisor
	logic signed [COORD_WIDTH:0] vx_s1;
	logic signed [COORD_WIDTH:0] vy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1 <= {b_vel_x[COORD_WIDTH-1], b_vel_x} - {a_vel_x[COORD_WIDTH-1], a_vel_x};
			vy_s1 <= {b_vel_y[COORD_WIDTH-1], b_vel_y} - {a_vel_y[COORD_WIDTH-1], a_vel_y};
		end
	end

	sac_tdiv #(.CW(COORD_WIDTH), .TW(TIME_WIDTH)) u_div_xent (
		.clk(clk), .en(en), .num(xent_s1), .den(vx_s1), .quo(qx_ent)
	);
	sac_tdiv #(.CW(COORD_WIDTH), .TW(TIME_WIDTH)) u_div_xext (
		.clk(clk), .en(en), .num(xext_s1), .den(vx_s1), .quo(qx_ext)
	);
	sac_tdiv #(.CW(COORD_WIDTH), .TW(TIME_WIDTH)) u_div_yent (
		.clk(clk), .en(en), .num(yent_s1), .den(vy_s1), .quo(qy_ent)
	);
	sac_tdiv #(.CW(COORD_WIDTH), .TW(TIME_WIDTH)) u_div_yext (
		.clk(clk), .en(en), .num(yext_s1), .den(vy_s1), .quo(qy_ext)
	);

	// axis decisions delayed to meet the quotients
	always_ff @(posedge clk) begin
		if (en) begin
			cx_q[0] <= cx_s1;
			cy_q[0] <= cy_s1;
			for (int i = 1; i < DL; i++) begin
				cx_q[i] <= cx_q[i-1];
				cy_q[i] <= cy_q[i-1];
			end
		end
	end

	sac_window #(.TW(TIME_WIDTH)) u_window (
		.clk(clk), .en(en),
		.ctrl_x(cx_q[DL-1]), .ctrl_y(cy_q[DL-1]),
		.qx_ent(qx_ent), .qx_ext(qx_ext), .qy_ent(qy_ent), .qy_ext(qy_ext),
		.frame_time(frame_time_q),
		.hit_s2(hit), .fct_s2(first_contact_time)
	);

	// a miss reports time zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> first_contact_time == '0)
		else $error("miss with nonzero contact time");

	// contact never lies beyond the frame
	a_hit_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> first_contact_time <= frame_time_q)
		else $error("contact time beyond frame");

	// a stall freezes the valid pipeline
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved during stall");

endmodule
